[rtl/core/lgssl_pkg.sv]
package lgssl_pkg;

  // Field widths of one input word and one result word.
  localparam int MODE_W        = 3;
  localparam int CHANNEL_W     = 5;
  localparam int LEVEL_W       = 12;
  localparam int CHAN_PER_CHIP = 16;

  // Wide enough to hold any channel count up to sixteen chips.
  localparam int CHAN_CNT_W    = 9;

  // Bit index within one grayscale level.
  localparam int BIT_IDX_W     = $clog2(LEVEL_W);

  // Operation codes carried in the mode field.
  typedef enum logic [MODE_W-1:0] {
    MODE_WRITE     = 3'd0,
    MODE_READ      = 3'd1,
    MODE_WRITE_ALL = 3'd2,
    MODE_START     = 3'd3,
    MODE_TICK      = 3'd4
  } mode_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic resolve;
    logic pop;
  } lgssl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_valid;
  } lgssl_sts_t;

  // One result word.
  typedef struct packed {
    logic [LEVEL_W-1:0] read_value;
    logic               serial_data;
    logic               clock_pulse;
    logic               latch_pulse;
    logic               busy_res;
  } result_t;

endpackage

[rtl/core/lgssl_item_if.sv]
interface lgssl_item_if import lgssl_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [MODE_W-1:0]    mode;
  logic [CHANNEL_W-1:0] channel;
  logic [LEVEL_W-1:0]   value;

  modport source (output valid, output mode, output channel, output value, input ready);
  modport sink   (input valid, input mode, input channel, input value, output ready);
endinterface

[rtl/core/lgssl_result_if.sv]
interface lgssl_result_if import lgssl_pkg::*;;
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] read_value;
  logic               serial_data;
  logic               clock_pulse;
  logic               latch_pulse;
  logic               busy_res;

  modport source (output valid, output read_value, output serial_data, output clock_pulse,
                  output latch_pulse, output busy_res, input ready);
  modport sink   (input valid, input read_value, input serial_data, input clock_pulse,
                  input latch_pulse, input busy_res, output ready);
endinterface

[rtl/core/lgssl_ctrl.sv]
module lgssl_ctrl import lgssl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       out_ready,
  input  lgssl_sts_t sts,
  output lgssl_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_ACCEPT  = 2'b01,
    ST_RESOLVE = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  // A word is taken only when the output register is free or drains this cycle.
  assign in_ready    = (state == ST_ACCEPT) && (!sts.out_valid || out_ready);
  assign cmd.accept  = in_valid && in_ready;
  assign cmd.resolve = (state == ST_RESOLVE);
  assign cmd.pop     = sts.out_valid && out_ready;

  // Accept, then resolve with the registered store read.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_ACCEPT: begin
        if (cmd.accept) begin
          state_next = ST_RESOLVE;
        end
      end
      ST_RESOLVE: begin
        state_next = ST_ACCEPT;
      end
      default: begin
        state_next = ST_ACCEPT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_ACCEPT;
    end else begin
      state <= state_next;
    end
  end

endmodule

[rtl/core/lgssl_dp.sv]
module lgssl_dp import lgssl_pkg::*; #(
  parameter int CHIPS = 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  lgssl_cmd_t           cmd,
  output lgssl_sts_t           sts,
  input  logic [MODE_W-1:0]    in_mode,
  input  logic [CHANNEL_W-1:0] in_channel,
  input  logic [LEVEL_W-1:0]   in_value,
  output result_t              res
);

  localparam int CHANNELS = CHIPS * CHAN_PER_CHIP;
  localparam int AW       = $clog2(CHANNELS);
  localparam logic [CHAN_CNT_W-1:0] ChanCount = CHAN_CNT_W'(CHANNELS);

  // Latched input word.
  mode_t                item_mode;
  logic [CHANNEL_W-1:0] item_channel;
  logic [LEVEL_W-1:0]   item_value;

  // Grayscale store: memory plus per-entry valid bits over a common base level.
  logic [LEVEL_W-1:0]  mem [CHANNELS];
  logic [LEVEL_W-1:0]  mem_q;
  logic                valid_q;
  logic [CHANNELS-1:0] valid_bits;
  logic [LEVEL_W-1:0]  base;

  // Shift sequencer state.
  logic                 updating;
  logic                 shifted_all;
  logic [AW-1:0]        chan_idx;
  logic [BIT_IDX_W-1:0] bit_idx;
  logic                 updating_next;
  logic                 shifted_all_next;
  logic [AW-1:0]        chan_idx_next;
  logic [BIT_IDX_W-1:0] bit_idx_next;

  logic                  out_valid;
  result_t               res_next;
  logic [CHAN_CNT_W-1:0] in_chan_ext;
  logic [CHAN_CNT_W-1:0] item_chan_ext;
  logic [AW-1:0]         rd_addr;
  logic [AW-1:0]         item_addr;
  logic [LEVEL_W-1:0]    word;
  logic                  in_range;
  logic                  wr_en;
  logic                  clr_all;

  assign sts.out_valid = out_valid;

  // Store address: the shift channel for a tick, else the channel field.
  assign in_chan_ext   = CHAN_CNT_W'(in_channel);
  assign item_chan_ext = CHAN_CNT_W'(item_channel);
  assign rd_addr       = (in_mode == MODE_TICK) ? chan_idx : in_chan_ext[AW-1:0];
  assign item_addr     = item_chan_ext[AW-1:0];
  assign in_range      = item_chan_ext < ChanCount;
  assign word          = valid_q ? mem_q : base;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_mode    <= mode_t'(in_mode);
      item_channel <= in_channel;
      item_value   <= in_value;
    end
  end

  // Store memory with registered read.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mem_q   <= mem[rd_addr];
      valid_q <= valid_bits[rd_addr];
    end
    if (wr_en) begin
      mem[item_addr] <= item_value;
    end
  end

  // Valid bits and base level; write-all resets every entry to a new base.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
      base       <= '0;
    end else if (clr_all) begin
      valid_bits <= '0;
      base       <= item_value;
    end else if (wr_en) begin
      valid_bits[item_addr] <= 1'b1;
    end
  end

  // Resolve one word against the current state.
  always_comb begin
    res_next         = '0;
    updating_next    = updating;
    shifted_all_next = shifted_all;
    chan_idx_next    = chan_idx;
    bit_idx_next     = bit_idx;
    wr_en            = 1'b0;
    clr_all          = 1'b0;
    unique case (item_mode)
      MODE_TICK: begin
        if (updating && !shifted_all) begin
          res_next.serial_data = word[bit_idx];
          res_next.clock_pulse = 1'b1;
          if (bit_idx == '0) begin
            bit_idx_next = BIT_IDX_W'(LEVEL_W - 1);
            if (chan_idx == '0) begin
              shifted_all_next = 1'b1;
            end else begin
              chan_idx_next = chan_idx - 1'b1;
            end
          end else begin
            bit_idx_next = bit_idx - 1'b1;
          end
        end else if (updating) begin
          res_next.latch_pulse = 1'b1;
          updating_next        = 1'b0;
        end
      end
      MODE_WRITE: begin
        wr_en = !updating && in_range;
      end
      MODE_READ: begin
        if (!updating && in_range) begin
          res_next.read_value = word;
        end
      end
      MODE_WRITE_ALL: begin
        clr_all = !updating;
      end
      MODE_START: begin
        if (!updating) begin
          updating_next        = 1'b1;
          shifted_all_next     = 1'b0;
          chan_idx_next        = AW'(CHANNELS - 1);
          bit_idx_next         = BIT_IDX_W'(LEVEL_W - 1);
          res_next.clock_pulse = 1'b1;
        end
      end
      default: begin
      end
    endcase
    res_next.busy_res = updating_next;
    if (!cmd.resolve) begin
      wr_en   = 1'b0;
      clr_all = 1'b0;
    end
  end

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      updating    <= 1'b0;
      shifted_all <= 1'b0;
      chan_idx    <= '0;
      bit_idx     <= '0;
    end else if (cmd.resolve) begin
      updating    <= updating_next;
      shifted_all <= shifted_all_next;
      chan_idx    <= chan_idx_next;
      bit_idx     <= bit_idx_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.resolve) begin
      out_valid <= 1'b1;
    end else if (cmd.pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.resolve) begin
      res <= res_next;
    end
  end

endmodule

[rtl/core/led_grayscale_store_serial_loader_core.sv]
// Channel  Direction  Word
// item     in         mode, channel, value
// result   out        read_value, serial_data, clock_pulse, latch_pulse, busy_res
//
// Every word is first accepted, and the accept cycle starts the store read; the
// next cycle resolves the word from the registered read data into the output register.
// A new word is accepted while a result waits only once that result drains.
// Asserting rst clears the store (per-entry valid bits) and the shift sequencer.
// Write-all completes like any other word, as one base level for every channel.
module led_grayscale_store_serial_loader_core import lgssl_pkg::*; #(
  parameter int CHIPS = 2
) (
  input logic           clk,
  input logic           rst,
  lgssl_item_if.sink    item,
  lgssl_result_if.source result
);

  lgssl_cmd_t cmd;
  lgssl_sts_t sts;
  result_t    res;

  lgssl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .out_ready (result.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lgssl_dp #(
    .CHIPS (CHIPS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .in_mode    (item.mode),
    .in_channel (item.channel),
    .in_value   (item.value),
    .res        (res)
  );

  // Result channel driven from the output register.
  assign result.valid       = sts.out_valid;
  assign result.read_value  = res.read_value;
  assign result.serial_data = res.serial_data;
  assign result.clock_pulse = res.clock_pulse;
  assign result.latch_pulse = res.latch_pulse;
  assign result.busy_res    = res.busy_res;

endmodule

[tb/sv/led_grayscale_store_serial_loader_core_tb.sv]
`timescale 1ns / 100ps

module led_grayscale_store_serial_loader_core_tb;
  import lgssl_pkg::*;

  localparam int CHIPS       = 2;
  localparam int CHANNELS    = CHIPS * CHAN_PER_CHIP;
  localparam int TOTAL_BITS  = CHANNELS * LEVEL_W;
  localparam int CYCLE_LIMIT = 400000;
  localparam int WORDS_PER_PHASE = 600;

  logic clk;
  logic rst;

  lgssl_item_if   item_ch ();
  lgssl_result_if result_ch ();

  led_grayscale_store_serial_loader_core #(
    .CHIPS(CHIPS)
  ) uut (
    .clk   (clk),
    .rst   (rst),
    .item  (item_ch),
    .result(result_ch)
  );

  // Shadow copy of the block's state.
  logic [LEVEL_W-1:0] gray_levels [CHANNELS];
  int unsigned        bits_shifted;
  bit                 shifting;

  // Result words still owed by the block, oldest first.
  result_t pending_results[$];

  int src_idle_pct;
  int snk_idle_pct;
  int mismatch_count;
  int unsigned cycles;

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: ends a hung run.
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("status: fail");
    $finish;
  end

  // Computes the result word of one accepted item and advances the shadow state.
  function automatic result_t predict_result(input logic [MODE_W-1:0] m,
                                             input logic [CHANNEL_W-1:0] ch,
                                             input logic [LEVEL_W-1:0] lvl);
    result_t     r;
    int unsigned slot;
    int unsigned bit_idx;
    int unsigned src_ch;
    r = '0;
    if (m == MODE_TICK) begin
      if (shifting) begin
        if (bits_shifted < TOTAL_BITS) begin
          // Highest channel goes out first, each level from its top bit down.
          slot          = bits_shifted / LEVEL_W;
          bit_idx       = LEVEL_W - 1 - (bits_shifted % LEVEL_W);
          src_ch        = CHANNELS - 1 - slot;
          r.serial_data = gray_levels[src_ch][bit_idx];
          r.clock_pulse = 1'b1;
          bits_shifted++;
        end else begin
          r.latch_pulse = 1'b1;
          bits_shifted  = 0;
          shifting      = 1'b0;
        end
      end
    end else if (!shifting) begin
      case (m)
        MODE_WRITE: begin
          if (ch < CHANNELS) gray_levels[ch] = lvl;
        end
        MODE_READ: begin
          if (ch < CHANNELS) r.read_value = gray_levels[ch];
        end
        MODE_WRITE_ALL: begin
          for (int i = 0; i < CHANNELS; i++) gray_levels[i] = lvl;
        end
        MODE_START: begin
          // The start gives one extra clock pulse with a zero data bit.
          shifting      = 1'b1;
          bits_shifted  = 0;
          r.clock_pulse = 1'b1;
        end
        default: begin
        end
      endcase
    end
    r.busy_res = shifting;
    return r;
  endfunction

  // Drives one word, waits for its handshake and records what it must produce.
  task automatic send_word(input logic [MODE_W-1:0] m, input logic [CHANNEL_W-1:0] ch,
                           input logic [LEVEL_W-1:0] lvl);
    while ($urandom_range(99) < src_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid   <= 1'b1;
    item_ch.mode    <= m;
    item_ch.channel <= ch;
    item_ch.value   <= lvl;
    do @(posedge clk); while (!item_ch.ready);
    pending_results.push_back(predict_result(m, ch, lvl));
  endtask

  // Holds the sender off until every owed result word has come back.
  task automatic wait_drained();
    item_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Levels lean toward the extremes now and then.
  function automatic logic [LEVEL_W-1:0] rand_level();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return LEVEL_W'($urandom_range(4095));
    endcase
  endfunction

  task automatic report_mismatch(input string field, input int want, input int got);
    $display("%0t: mismatch on %s, expected %0d, actual %0d", $time, field, want, got);
    mismatch_count++;
  endtask

  // Checks every accepted result word against the oldest expectation.
  initial begin
    result_t want;
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_ch.valid && result_ch.ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result word with nothing expected, expected none, actual %0d",
                   $time, result_ch.read_value);
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          if (result_ch.read_value !== want.read_value)
            report_mismatch("read_value", want.read_value, result_ch.read_value);
          if (result_ch.serial_data !== want.serial_data)
            report_mismatch("serial_data", want.serial_data, result_ch.serial_data);
          if (result_ch.clock_pulse !== want.clock_pulse)
            report_mismatch("clock_pulse", want.clock_pulse, result_ch.clock_pulse);
          if (result_ch.latch_pulse !== want.latch_pulse)
            report_mismatch("latch_pulse", want.latch_pulse, result_ch.latch_pulse);
          if (result_ch.busy_res !== want.busy_res)
            report_mismatch("busy_res", want.busy_res, result_ch.busy_res);
        end
      end
      result_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Idle-state corners: ticks and unused modes do nothing, the cleared store reads zero.
  task automatic test_idle_corners();
    send_word(MODE_TICK, '0, '0);
    send_word(3'd5, '1, '1);
    send_word(3'd6, 5'd10, 12'h5A5);
    send_word(3'd7, '1, '1);
    send_word(MODE_READ, '0, '1);
    send_word(MODE_READ, '1, '0);
  endtask

  // Single-channel and whole-store writes, read back at the channel extremes.
  task automatic test_store_access();
    send_word(MODE_WRITE, '0, '1);
    send_word(MODE_WRITE, '1, 12'hA5A);
    send_word(MODE_WRITE, 5'd15, 12'h555);
    send_word(MODE_READ, '0, '0);
    send_word(MODE_READ, '1, '0);
    send_word(MODE_READ, 5'd15, '0);
    send_word(MODE_WRITE_ALL, 5'd3, 12'h800);
    send_word(MODE_WRITE, 5'd31, 12'h001);
    send_word(MODE_READ, 5'd7, '0);
    send_word(MODE_READ, 5'd31, '0);
  endtask

  // Start of an update, then accesses that must be ignored while it shifts.
  task automatic test_update_start();
    send_word(MODE_START, '0, '0);
    send_word(MODE_TICK, '0, '0);
    send_word(MODE_TICK, '1, '1);
    send_word(MODE_WRITE, '1, '1);
    send_word(MODE_READ, '1, '0);
    send_word(MODE_WRITE_ALL, '0, '1);
    send_word(MODE_START, '0, '0);
    send_word(3'd7, '1, '1);
    send_word(MODE_TICK, '0, '0);
    wait_drained();
  endtask

  // Mostly complete updates with random store contents, plus noise.
  task automatic test_random_traffic(input int count);
    logic [MODE_W-1:0] m;
    int unsigned       pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (shifting) begin
        if (pick < 92) m = MODE_TICK;
        else m = MODE_W'($urandom_range(7));
      end else if (pick < 40) m = MODE_WRITE;
      else if (pick < 70) m = MODE_READ;
      else if (pick < 74) m = MODE_WRITE_ALL;
      else if (pick < 77) m = MODE_START;
      else if (pick < 88) m = MODE_TICK;
      else m = MODE_W'($urandom_range(7, 5));
      send_word(m, CHANNEL_W'($urandom_range(31)), rand_level());
    end
  endtask

  // Test sequence.
  initial begin
    rst             = 1'b1;
    item_ch.valid   = 1'b0;
    item_ch.mode    = '0;
    item_ch.channel = '0;
    item_ch.value   = '0;
    mismatch_count  = 0;
    bits_shifted    = 0;
    shifting        = 1'b0;
    for (int i = 0; i < CHANNELS; i++) gray_levels[i] = '0;
    src_idle_pct = 9;
    snk_idle_pct = 76;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_idle_corners();
    test_store_access();
    test_update_start();
    test_random_traffic(WORDS_PER_PHASE);
    wait_drained();

    src_idle_pct = 76;
    snk_idle_pct = 9;
    test_random_traffic(WORDS_PER_PHASE);

    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_random_traffic(WORDS_PER_PHASE);

    wait_drained();
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: result words missing, expected 0 pending, actual %0d pending",
               $time, pending_results.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
